@@ design/grid_block_resample_3d_macros.svh @@
// Assertion helpers for the grid resampler.
// Both expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef GRID_BLOCK_RESAMPLE_3D_MACROS_SVH
`define GRID_BLOCK_RESAMPLE_3D_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GBR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grid_block_resample_3d: same-cycle check failed");

// next-cycle implication
`define GBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grid_block_resample_3d: next-cycle check failed");

`else

`define GBR_ASSERT_IMPLY(lbl, ante, cons)
`define GBR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/gbr_pkg.sv @@
package gbr_pkg;

    // field and storage widths
    localparam int VALUE_W    = 32;
    localparam int ACC_W      = 40;
    localparam int FRAC_BITS  = 16;
    localparam int RECIP_W    = 17;
    localparam int IDX_W      = 24;
    localparam int CELLS_W    = 7;
    localparam int FACTOR_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int PLANE_CELLS = 4096;
    localparam int PLANE_AW   = 12;
    localparam int PROD_W     = ACC_W + RECIP_W + 1;

    localparam logic [CELLS_W-1:0]  MAX_CELLS  = 7'd64;
    localparam logic [FACTOR_W-1:0] MAX_FACTOR = 3'd4;
    localparam logic [RECIP_W-1:0]  RECIP_ONE  = 17'h10000;

    typedef enum logic [1:0] {
        MODE_UPSAMPLE = 2'd0,
        MODE_AVERAGE  = 2'd1,
        MODE_SUM      = 2'd2,
        MODE_PASS     = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_LAT_CELLS  = 3'd1,
        REG_LON_CELLS  = 3'd2,
        REG_DEPTH_CELLS = 3'd3,
        REG_LAT_FACTOR = 3'd4,
        REG_LON_FACTOR = 3'd5,
        REG_DEPTH_FACTOR = 3'd6,
        REG_RECIPROCAL = 3'd7
    } cfg_reg_t;

    // zero acts as one, anything past 64 as 64
    function automatic logic [CELLS_W-1:0] clamp_cells(input logic [CELLS_W-1:0] v);
        logic [CELLS_W-1:0] r;
        if (v == '0) r = CELLS_W'(1);
        else if (v > MAX_CELLS) r = MAX_CELLS;
        else r = v;
        return r;
    endfunction

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
        logic [FACTOR_W-1:0] r;
        if (v == '0) r = FACTOR_W'(1);
        else if (v > MAX_FACTOR) r = MAX_FACTOR;
        else r = v;
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] clamp_recip(input logic [RECIP_W-1:0] v);
        return (v > RECIP_ONE) ? RECIP_ONE : v;
    endfunction

    // 41-bit sum down to a 40-bit accumulator
    function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] v);
        logic [ACC_W-1:0] r;
        if (v[ACC_W] == v[ACC_W-1]) r = v[ACC_W-1:0];
        else if (v[ACC_W]) r = {1'b1, {(ACC_W-1){1'b0}}};
        else r = {1'b0, {(ACC_W-1){1'b1}}};
        return r;
    endfunction

    // wide signed value down to a Q16.16 result
    function automatic logic [VALUE_W-1:0] sat_value(input logic [PROD_W-1:0] v);
        logic [PROD_W-VALUE_W:0] top;
        logic [VALUE_W-1:0]      r;
        top = v[PROD_W-1:VALUE_W-1];
        if (top == '0 || top == '1) r = v[VALUE_W-1:0];
        else if (v[PROD_W-1]) r = {1'b1, {(VALUE_W-1){1'b0}}};
        else r = {1'b0, {(VALUE_W-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ design/gbr_ram.sv @@
module gbr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/grid_block_resample_3d.sv @@
// Path: an accepted item passes the s1, s2, s3 and output registers before its first result.
// Throughput: one item per cycle in downsample and pass-through modes while the output
//   is not stalled, set by the accumulator memory read-modify-write loop; upsample emits
//   one result per cycle while m_ready is high, fl*fo*fd results per item.
// Reset (aresetn, synchronous): registers to defaults, stream position to zero, and
//   s_ready low while settle_reg counts down (also after each config write); accumulators not cleared.
`include "grid_block_resample_3d_macros.svh"

module grid_block_resample_3d (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gbr_pkg::VALUE_W-1:0]  s_sample_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gbr_pkg::IDX_W-1:0]           m_cell_index,
    output logic signed [gbr_pkg::VALUE_W-1:0]  m_cell_value,
    output logic                                m_last_of_run,
    output logic                                m_grid_done
);

    import gbr_pkg::*;

    localparam int NL_W   = 9;
    localparam int CP_W   = 13;
    localparam int P_W    = 17;
    localparam int RS_W   = 11;
    localparam int TOT_W  = 19;
    localparam int POS_W  = 6;
    localparam int SUB_W  = 2;
    localparam int LAT_W  = 8;
    localparam int ROW_W  = 16;
    localparam int PT_W   = 18;
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]    idx;
        logic [PLANE_AW-1:0] pi;
        logic                first;
        logic                emit;
        logic                done;
    } s1_t;

    typedef struct packed {
        logic [ACC_W-1:0]    acc;
        logic [IDX_W-1:0]    idx;
        logic [PLANE_AW-1:0] pi;
        logic                emit;
        logic                done;
    } s2_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              rnd;
        logic [IDX_W-1:0]  idx;
        logic              done;
    } s3_t;

    // ---------------- configuration registers ----------------
    mode_t                mode_reg;
    logic [CELLS_W-1:0]   cl_reg, co_reg, cd_reg;
    logic [FACTOR_W-1:0]  fl_reg, fo_reg, fd_reg;
    logic [RECIP_W-1:0]   recip_reg;
    logic [2:0]           settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PASS;
            cl_reg    <= CELLS_W'(1);
            co_reg    <= CELLS_W'(1);
            cd_reg    <= CELLS_W'(1);
            fl_reg    <= FACTOR_W'(1);
            fo_reg    <= FACTOR_W'(1);
            fd_reg    <= FACTOR_W'(1);
            recip_reg <= RECIP_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_MODE:         mode_reg  <= mode_t'(cfg_wr_data[1:0]);
                REG_LAT_CELLS:    cl_reg    <= cfg_wr_data[CELLS_W-1:0];
                REG_LON_CELLS:    co_reg    <= cfg_wr_data[CELLS_W-1:0];
                REG_DEPTH_CELLS:  cd_reg    <= cfg_wr_data[CELLS_W-1:0];
                REG_LAT_FACTOR:   fl_reg    <= cfg_wr_data[FACTOR_W-1:0];
                REG_LON_FACTOR:   fo_reg    <= cfg_wr_data[FACTOR_W-1:0];
                REG_DEPTH_FACTOR: fd_reg    <= cfg_wr_data[FACTOR_W-1:0];
                REG_RECIPROCAL:   recip_reg <= cfg_wr_data[RECIP_W-1:0];
                default:          mode_reg  <= mode_reg;
            endcase
        end
    end

    // derived sizes settle through four register levels; input held off meanwhile
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    // ---------------- derived grid sizes ----------------
    logic [CELLS_W-1:0]  cl_d_reg, co_d_reg, cd_d_reg;
    logic [FACTOR_W-1:0] fl_d_reg, fo_d_reg, fd_d_reg;
    logic [RECIP_W-1:0]  recip_d_reg;
    logic [NL_W-1:0]     nl_reg, no_reg;
    logic [CP_W-1:0]     cp_reg;
    logic [P_W-1:0]      pstep_reg;
    logic [RS_W-1:0]     rstep_up_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [TOT_W-1:0]    pstep_up_reg;

    always_ff @(posedge aclk) begin
        cl_d_reg     <= clamp_cells(cl_reg);
        co_d_reg     <= clamp_cells(co_reg);
        cd_d_reg     <= clamp_cells(cd_reg);
        fl_d_reg     <= clamp_factor(fl_reg);
        fo_d_reg     <= clamp_factor(fo_reg);
        fd_d_reg     <= clamp_factor(fd_reg);
        recip_d_reg  <= clamp_recip(recip_reg);
        nl_reg       <= NL_W'(cl_d_reg) * NL_W'(fl_d_reg);
        no_reg       <= NL_W'(co_d_reg) * NL_W'(fo_d_reg);
        cp_reg       <= CP_W'(cl_d_reg) * CP_W'(co_d_reg);
        pstep_reg    <= P_W'(nl_reg) * P_W'(no_reg);
        rstep_up_reg <= RS_W'(fo_d_reg) * RS_W'(nl_reg);
        total_reg    <= TOT_W'(cp_reg) * TOT_W'(cd_d_reg);
        pstep_up_reg <= TOT_W'(fd_d_reg) * TOT_W'(pstep_reg);
    end

    logic is_up, is_pass, is_down, is_avg;
    logic [CELLS_W-1:0]  cl_dec, co_dec, cd_dec;
    logic [FACTOR_W-1:0] fl_dec, fo_dec, fd_dec;
    logic [SUB_W-1:0]    fl_m1, fo_m1, fd_m1;
    logic [SUB_W-1:0]    subl_m1, subo_m1, subd_m1;
    logic [LAT_W-1:0]    lat_step;
    logic [ROW_W-1:0]    row_step;
    logic [IDX_W-1:0]    plane_step;

    assign is_up   = (mode_reg == MODE_UPSAMPLE);
    assign is_pass = (mode_reg == MODE_PASS);
    assign is_avg  = (mode_reg == MODE_AVERAGE);
    assign is_down = !is_up && !is_pass;

    assign cl_dec = cl_d_reg - CELLS_W'(1);
    assign co_dec = co_d_reg - CELLS_W'(1);
    assign cd_dec = cd_d_reg - CELLS_W'(1);
    assign fl_dec = fl_d_reg - FACTOR_W'(1);
    assign fo_dec = fo_d_reg - FACTOR_W'(1);
    assign fd_dec = fd_d_reg - FACTOR_W'(1);
    assign fl_m1  = fl_dec[SUB_W-1:0];
    assign fo_m1  = fo_dec[SUB_W-1:0];
    assign fd_m1  = fd_dec[SUB_W-1:0];

    // source grid is fine only when downsampling
    assign subl_m1 = is_down ? fl_m1 : '0;
    assign subo_m1 = is_down ? fo_m1 : '0;
    assign subd_m1 = is_down ? fd_m1 : '0;

    // index steps per coarse position: fine-grid strides when upsampling
    assign lat_step   = is_up ? LAT_W'(fl_d_reg) : LAT_W'(1);
    assign row_step   = is_up ? ROW_W'(rstep_up_reg) : ROW_W'(cl_d_reg);
    assign plane_step = is_up ? IDX_W'(pstep_up_reg) : IDX_W'(cp_reg);

    // ---------------- stream position ----------------
    logic [POS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [SUB_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [LAT_W-1:0] lat_base_reg;
    logic [ROW_W-1:0] row_base_reg;
    logic [IDX_W-1:0] plane_base_reg;
    logic [PT_W-1:0]  pt_reg;

    logic ox_end, oy_end, oz_end, cx_end, cy_end, cz_end;
    logic blk_first, blk_last, grid_end, pt_end;
    logic [TOT_W-1:0] total_m1;
    logic accept;

    assign ox_end = (ox_reg == subl_m1);
    assign oy_end = (oy_reg == subo_m1);
    assign oz_end = (oz_reg == subd_m1);
    assign cx_end = (cx_reg == cl_dec[POS_W-1:0]);
    assign cy_end = (cy_reg == co_dec[POS_W-1:0]);
    assign cz_end = (cz_reg == cd_dec[POS_W-1:0]);

    assign blk_first = (ox_reg == '0) && (oy_reg == '0) && (oz_reg == '0);
    assign blk_last  = ox_end && oy_end && oz_end;
    assign grid_end  = blk_last && cx_end && cy_end && cz_end;
    assign total_m1  = total_reg - TOT_W'(1);
    assign pt_end    = (TOT_W'(pt_reg) == total_m1);

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            lat_base_reg   <= '0;
            row_base_reg   <= '0;
            plane_base_reg <= '0;
            pt_reg         <= '0;
        end else if (accept) begin
            if (is_pass) begin
                pt_reg <= pt_end ? '0 : pt_reg + PT_W'(1);
            end else if (!ox_end) begin
                ox_reg <= ox_reg + SUB_W'(1);
            end else begin
                ox_reg <= '0;
                if (!cx_end) begin
                    cx_reg       <= cx_reg + POS_W'(1);
                    lat_base_reg <= lat_base_reg + lat_step;
                end else begin
                    cx_reg       <= '0;
                    lat_base_reg <= '0;
                    if (!oy_end) begin
                        oy_reg <= oy_reg + SUB_W'(1);
                    end else begin
                        oy_reg <= '0;
                        if (!cy_end) begin
                            cy_reg       <= cy_reg + POS_W'(1);
                            row_base_reg <= row_base_reg + row_step;
                        end else begin
                            cy_reg       <= '0;
                            row_base_reg <= '0;
                            if (!oz_end) begin
                                oz_reg <= oz_reg + SUB_W'(1);
                            end else begin
                                oz_reg <= '0;
                                if (!cz_end) begin
                                    cz_reg         <= cz_reg + POS_W'(1);
                                    plane_base_reg <= plane_base_reg + plane_step;
                                end else begin
                                    cz_reg         <= '0;
                                    plane_base_reg <= '0;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    logic adv1, adv2, adv3, out_free, run_last;

    assign out_free = !m_valid_reg || (m_ready && run_last);
    assign adv3     = v3_reg && out_free;
    assign adv2     = v2_reg && (!s2_reg.emit || !v3_reg || adv3);
    assign adv1     = v1_reg && (!v2_reg || adv2);
    assign s_ready  = (settle_reg == '0) && (!v1_reg || adv1);
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= accept || (v1_reg && !adv1);
            v2_reg <= adv1 || (v2_reg && !adv2);
            v3_reg <= (adv2 && s2_reg.emit) || (v3_reg && !adv3);
        end
    end

    // ---------------- input stage: index, plane slot, memory read ----------------
    logic [PLANE_AW-1:0] in_pi;

    assign in_pi = PLANE_AW'(lat_base_reg) + row_base_reg[PLANE_AW-1:0];

    always_comb begin
        s1_next.value = s_sample_value;
        s1_next.idx   = is_pass ? IDX_W'(pt_reg)
                      : IDX_W'(lat_base_reg) + IDX_W'(row_base_reg) + plane_base_reg;
        s1_next.pi    = in_pi;
        s1_next.first = blk_first;
        s1_next.emit  = !is_down || blk_last;
        s1_next.done  = is_pass ? pt_end : grid_end;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- accumulate stage ----------------
    logic [ACC_W-1:0] rd_data, acc_prev, v1_ext;
    logic [ACC_W:0]   acc_sum;
    logic             ram_we;

    gbr_ram #(
        .WIDTH (ACC_W),
        .DEPTH (PLANE_CELLS)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_reg.pi),
        .wr_data (s2_next.acc),
        .rd_en   (accept),
        .rd_addr (in_pi),
        .rd_data (rd_data)
    );

    // the item one stage ahead can write its slot in the cycle this one is read
    assign acc_prev = (v2_reg && s2_reg.pi == s1_reg.pi) ? s2_reg.acc : rd_data;
    assign v1_ext   = {{(ACC_W-VALUE_W){s1_reg.value[VALUE_W-1]}}, s1_reg.value};
    assign acc_sum  = {acc_prev[ACC_W-1], acc_prev} + {v1_ext[ACC_W-1], v1_ext};
    assign ram_we   = adv1 && is_down;

    always_comb begin
        s2_next.acc  = (is_down && !s1_reg.first) ? sat_acc(acc_sum) : v1_ext;
        s2_next.idx  = s1_reg.idx;
        s2_next.pi   = s1_reg.pi;
        s2_next.emit = s1_reg.emit;
        s2_next.done = s1_reg.done;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_reg <= s2_next;
        end
    end

    // ---------------- scale stage ----------------
    logic signed [PROD_W-1:0] acc_wide, recip_wide, prod_c;

    assign acc_wide   = $signed({{(PROD_W-ACC_W){s2_reg.acc[ACC_W-1]}}, s2_reg.acc});
    assign recip_wide = $signed({{(PROD_W-RECIP_W){1'b0}}, recip_d_reg});
    assign prod_c     = acc_wide * recip_wide;

    always_comb begin
        s3_next.prod = is_avg ? prod_c : acc_wide;
        s3_next.rnd  = is_avg;
        s3_next.idx  = s2_reg.idx;
        s3_next.done = s2_reg.done;
    end

    always_ff @(posedge aclk) begin
        if (adv2 && s2_reg.emit) begin
            s3_reg <= s3_next;
        end
    end

    // ---------------- output stage and replication run ----------------
    logic [PROD_W-1:0]        rounded_u;
    logic signed [PROD_W-1:0] shifted;
    logic [VALUE_W-1:0]       val_next;
    logic                     run_up_reg;
    logic [SUB_W-1:0]         run_a_reg, run_b_reg, run_c_reg;
    logic [IDX_W-1:0]         idx_reg, base_a_reg, base_b_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic                     done_reg;
    logic                     step;

    // round half up, then floor shift out the fraction
    assign rounded_u = s3_reg.prod + ROUND_HALF;
    assign shifted   = $signed(rounded_u) >>> FRAC_BITS;
    assign val_next  = s3_reg.rnd ? sat_value(shifted) : sat_value(s3_reg.prod);

    assign run_last = !run_up_reg
                   || (run_a_reg == fl_m1 && run_b_reg == fo_m1 && run_c_reg == fd_m1);
    assign step     = m_valid_reg && m_ready && !run_last && !adv3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            run_up_reg  <= 1'b0;
            run_a_reg   <= '0;
            run_b_reg   <= '0;
            run_c_reg   <= '0;
        end else if (adv3) begin
            m_valid_reg <= 1'b1;
            run_up_reg  <= is_up;
            run_a_reg   <= '0;
            run_b_reg   <= '0;
            run_c_reg   <= '0;
        end else if (m_valid_reg && m_ready) begin
            if (run_last) begin
                m_valid_reg <= 1'b0;
            end else if (run_c_reg != fd_m1) begin
                run_c_reg <= run_c_reg + SUB_W'(1);
            end else begin
                run_c_reg <= '0;
                if (run_b_reg != fo_m1) begin
                    run_b_reg <= run_b_reg + SUB_W'(1);
                end else begin
                    run_b_reg <= '0;
                    run_a_reg <= run_a_reg + SUB_W'(1);
                end
            end
        end
    end

    // depth varies fastest within a run, then lon, then lat
    always_ff @(posedge aclk) begin
        if (adv3) begin
            idx_reg    <= s3_reg.idx;
            base_a_reg <= s3_reg.idx;
            base_b_reg <= s3_reg.idx;
            value_reg  <= val_next;
            done_reg   <= s3_reg.done;
        end else if (step) begin
            if (run_c_reg != fd_m1) begin
                idx_reg <= idx_reg + IDX_W'(pstep_reg);
            end else if (run_b_reg != fo_m1) begin
                base_b_reg <= base_b_reg + IDX_W'(nl_reg);
                idx_reg    <= base_b_reg + IDX_W'(nl_reg);
            end else begin
                base_a_reg <= base_a_reg + IDX_W'(1);
                base_b_reg <= base_a_reg + IDX_W'(1);
                idx_reg    <= base_a_reg + IDX_W'(1);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cell_index  = idx_reg;
    assign m_cell_value  = $signed(value_reg);
    assign m_last_of_run = run_last;
    assign m_grid_done   = done_reg;

    // ---------------- checks ----------------
    `GBR_ASSERT_IMPLY(a_run_in_range, m_valid_reg && run_up_reg, run_a_reg <= fl_m1 && run_b_reg <= fo_m1 && run_c_reg <= fd_m1)
    `GBR_ASSERT_IMPLY(a_pass_index, m_valid_reg && !run_up_reg && is_pass && settle_reg == '0, m_cell_index < IDX_W'(total_reg))
    `GBR_ASSERT_IMPLY(a_pos_in_range, settle_reg == '0, cx_reg <= cl_dec[POS_W-1:0] && cy_reg <= co_dec[POS_W-1:0] && cz_reg <= cd_dec[POS_W-1:0])
    `GBR_ASSERT_NEXT(a_run_holds_input, m_valid_reg && !run_last && !m_ready, m_valid_reg && !adv3)

endmodule

@@ sim/grid_block_resample_3d_tb.sv @@
`timescale 1ns / 1ps

module grid_block_resample_3d_tb;
    import gbr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 65;
    localparam int MAX_REPORTS  = 40;
    localparam int CELL_CAP     = 64;
    localparam int FACTOR_CAP   = 4;
    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -ACC_HI - 1;

    // one cell of the target grid as the block reports it
    typedef struct {
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_run;
        logic                      grid_done;
    } cell_result_t;

    logic                        aclk;
    logic                        aresetn        = 1'b0;
    logic                        cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_wr_index   = '0;
    logic [CFG_DATA_W-1:0]       cfg_wr_data    = '0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic signed [VALUE_W-1:0]   s_sample_value = '0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic [IDX_W-1:0]            m_cell_index;
    logic signed [VALUE_W-1:0]   m_cell_value;
    logic                        m_last_of_run;
    logic                        m_grid_done;

    grid_block_resample_3d dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_index   (m_cell_index),
        .m_cell_value   (m_cell_value),
        .m_last_of_run  (m_last_of_run),
        .m_grid_done    (m_grid_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cells still owed by the block, oldest first
    cell_result_t expected_cells[$];

    int          errors          = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int          random_items    = 0;
    int          settings_run    = 0;
    int unsigned burst_left      = 0;
    int          hold_requests   = 0;
    int          hold_served     = 0;
    int          hold_left       = 0;
    int          rx_style        = 0;
    int          rx_left         = 0;

    // resampler state as the testbench tracks it
    mode_t                     cfg_mode;
    logic [CELLS_W-1:0]        cfg_lat_cells, cfg_lon_cells, cfg_depth_cells;
    logic [FACTOR_W-1:0]       cfg_lat_fac, cfg_lon_fac, cfg_depth_fac;
    logic [RECIP_W-1:0]        cfg_recip;
    logic [7:0]                pos_lat, pos_lon, pos_depth;
    logic [IDX_W-1:0]          pass_next;
    logic signed [ACC_W-1:0]   plane_sum [PLANE_CELLS];

    function automatic int unsigned eff_cells(input logic [CELLS_W-1:0] v);
        if (v == 0) return 1;
        if (v > CELL_CAP) return CELL_CAP;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_factor(input logic [FACTOR_W-1:0] v);
        if (v == 0) return 1;
        if (v > FACTOR_CAP) return FACTOR_CAP;
        return 32'(v);
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_q16(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[VALUE_W-1:0];
    endfunction

    function automatic longint sat_running_sum(input longint x);
        if (x > ACC_HI) return ACC_HI;
        if (x < ACC_LO) return ACC_LO;
        return x;
    endfunction

    function automatic void restart_stream();
        pos_lat   = '0;
        pos_lon   = '0;
        pos_depth = '0;
        pass_next = '0;
    endfunction

    function automatic void model_reset();
        cfg_mode        = MODE_PASS;
        cfg_lat_cells   = 7'd1;
        cfg_lon_cells   = 7'd1;
        cfg_depth_cells = 7'd1;
        cfg_lat_fac     = 3'd1;
        cfg_lon_fac     = 3'd1;
        cfg_depth_fac   = 3'd1;
        cfg_recip       = RECIP_ONE;
        restart_stream();
    endfunction

    // any write restarts the stream
    function automatic void model_config(input cfg_reg_t which,
                                         input logic [CFG_DATA_W-1:0] data);
        case (which)
            REG_MODE:         cfg_mode        = mode_t'(data[1:0]);
            REG_LAT_CELLS:    cfg_lat_cells   = data[CELLS_W-1:0];
            REG_LON_CELLS:    cfg_lon_cells   = data[CELLS_W-1:0];
            REG_DEPTH_CELLS:  cfg_depth_cells = data[CELLS_W-1:0];
            REG_LAT_FACTOR:   cfg_lat_fac     = data[FACTOR_W-1:0];
            REG_LON_FACTOR:   cfg_lon_fac     = data[FACTOR_W-1:0];
            REG_DEPTH_FACTOR: cfg_depth_fac   = data[FACTOR_W-1:0];
            REG_RECIPROCAL:   cfg_recip       = data[RECIP_W-1:0];
            default: ;
        endcase
        restart_stream();
    endfunction

    // works out the cells that one accepted sample produces
    function automatic void predict_sample(input logic signed [VALUE_W-1:0] v);
        int unsigned cl, co, cd, fl, fo, fd, sl, so, sd, x, y, z;
        int unsigned a, b, c, n, runs, idx, plane;
        longint acc, scaled;
        logic [RECIP_W-1:0] recip;
        bit done, first, last;
        cell_result_t r;
        cl = eff_cells(cfg_lat_cells);
        co = eff_cells(cfg_lon_cells);
        cd = eff_cells(cfg_depth_cells);
        fl = eff_factor(cfg_lat_fac);
        fo = eff_factor(cfg_lon_fac);
        fd = eff_factor(cfg_depth_fac);

        // pass-through: next index, wraps after the last coarse cell
        if (cfg_mode == MODE_PASS) begin
            runs = cl * co * cd;
            idx  = 32'(pass_next);
            if (idx >= runs) idx = 0;
            done = (idx + 1 == runs);
            r.index       = idx[IDX_W-1:0];
            r.value       = v;
            r.last_of_run = 1'b1;
            r.grid_done   = done;
            expected_cells.push_back(r);
            pass_next = done ? '0 : IDX_W'(idx + 1);
            return;
        end

        if (cfg_mode == MODE_UPSAMPLE) begin
            sl = cl;
            so = co;
            sd = cd;
        end else begin
            sl = cl * fl;
            so = co * fo;
            sd = cd * fd;
        end
        x = 32'(pos_lat);
        y = 32'(pos_lon);
        z = 32'(pos_depth);
        if (x >= sl) x = 0;
        if (y >= so) y = 0;
        if (z >= sd) z = 0;
        done = (x + 1 == sl) && (y + 1 == so) && (z + 1 == sd);

        if (cfg_mode == MODE_UPSAMPLE) begin
            // one copy per covered fine cell, depth offset innermost
            runs = fl * fo * fd;
            n    = 0;
            for (a = 0; a < fl; a++)
                for (b = 0; b < fo; b++)
                    for (c = 0; c < fd; c++) begin
                        idx = (x * fl + a) + cl * fl * (y * fo + b)
                            + cl * fl * co * fo * (z * fd + c);
                        r.index       = idx[IDX_W-1:0];
                        r.value       = v;
                        r.last_of_run = (n + 1 == runs);
                        r.grid_done   = done;
                        expected_cells.push_back(r);
                        n++;
                    end
        end else begin
            // downsample: first contributor loads, the rest accumulate
            first = (x % fl == 0) && (y % fo == 0) && (z % fd == 0);
            last  = (x % fl == fl - 1) && (y % fo == fo - 1) && (z % fd == fd - 1);
            plane = ((x / fl) + cl * (y / fo)) % PLANE_CELLS;
            acc = first ? longint'(v)
                        : sat_running_sum(longint'(plane_sum[plane]) + longint'(v));
            plane_sum[plane] = acc[ACC_W-1:0];
            if (last) begin
                idx = x / fl + cl * (y / fo) + cl * co * (z / fd);
                if (cfg_mode == MODE_SUM) begin
                    r.value = sat_q16(acc);
                end else begin
                    // round half up
                    recip  = (cfg_recip > RECIP_ONE) ? RECIP_ONE : cfg_recip;
                    scaled = acc * longint'(recip) + (longint'(1) <<< (FRAC_BITS - 1));
                    r.value = sat_q16(scaled >>> FRAC_BITS);
                end
                r.index       = idx[IDX_W-1:0];
                r.last_of_run = 1'b1;
                r.grid_done   = done;
                expected_cells.push_back(r);
            end
        end

        // step the source position, lat fastest
        x++;
        if (x >= sl) begin
            x = 0;
            y++;
            if (y >= so) begin
                y = 0;
                z++;
                if (z >= sd) z = 0;
            end
        end
        pos_lat   = x[7:0];
        pos_lon   = y[7:0];
        pos_depth = z[7:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return int'($urandom_range(0, 511)) - 256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CELLS_W-1:0] pick_cells();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return CELLS_W'($urandom_range(64, 127));
            default: return CELLS_W'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [RECIP_W-1:0] pick_recip();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RECIP_ONE;
            2: return RECIP_W'($urandom_range(65537, 131071));
            default: return RECIP_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // sender: bursts of random length with random gaps in between
    task automatic send_sample(input logic signed [VALUE_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_sample_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sample(v);
        items_sent++;
    endtask

    // drop valid, let every owed cell arrive, then let the pipeline empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // leaves the write enable high so back-to-back writes need no toggle
    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= which;
        cfg_wr_data  <= data;
        @(posedge aclk);
        model_config(which, data);
    endtask

    task automatic apply_setting(input mode_t mode,
                                 input logic [CELLS_W-1:0] lat_cells, lon_cells, depth_cells,
                                 input logic [FACTOR_W-1:0] lat_f, lon_f, depth_f,
                                 input logic [RECIP_W-1:0] recip);
        wait_idle();
        write_reg(REG_MODE,         CFG_DATA_W'(mode));
        write_reg(REG_LAT_CELLS,    CFG_DATA_W'(lat_cells));
        write_reg(REG_LON_CELLS,    CFG_DATA_W'(lon_cells));
        write_reg(REG_DEPTH_CELLS,  CFG_DATA_W'(depth_cells));
        write_reg(REG_LAT_FACTOR,   CFG_DATA_W'(lat_f));
        write_reg(REG_LON_FACTOR,   CFG_DATA_W'(lon_f));
        write_reg(REG_DEPTH_FACTOR, CFG_DATA_W'(depth_f));
        write_reg(REG_RECIPROCAL,   CFG_DATA_W'(recip));
        cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    // reset defaults: 1x1x1 pass-through, each item is the whole grid
    task automatic test_reset_defaults();
        send_sample(32'sh7FFFFFFF);
        send_sample(32'sh80000000);
    endtask

    // pass-through index wraps after the last coarse cell; lon count 0 acts as 1
    task automatic test_pass_wrap();
        apply_setting(MODE_PASS, 7'd3, 7'd0, 7'd1, 3'd1, 3'd1, 3'd1, RECIP_ONE);
        send_sample(32'sh0);
        send_sample(-32'sd1);
        send_sample(32'sh1);
        send_sample(32'sh0000_8000);
    endtask

    // factor 7 acts as 4, factor 0 as 1
    task automatic test_upsample_clamped();
        apply_setting(MODE_UPSAMPLE, 7'd2, 7'd1, 7'd1, 3'd7, 3'd0, 3'd2, RECIP_ONE);
        send_sample(-32'sd1);
        send_sample(32'sh7FFFFFFF);
    endtask

    // sums of extreme values saturate to Q16.16 limits
    task automatic test_sum_saturation();
        apply_setting(MODE_SUM, 7'd1, 7'd1, 7'd1, 3'd2, 3'd2, 3'd1, RECIP_ONE);
        repeat (4) send_sample(32'sh7FFFFFFF);
        repeat (4) send_sample(32'sh80000000);
    endtask

    // half reciprocal: 1.5 rounds to 2, -1.5 rounds to -1
    task automatic test_average_rounding();
        apply_setting(MODE_AVERAGE, 7'd1, 7'd1, 7'd1, 3'd1, 3'd1, 3'd2, 17'd32768);
        send_sample(32'sd1);
        send_sample(32'sd2);
        send_sample(-32'sd1);
        send_sample(-32'sd2);
    endtask

    // a lone write mid-cell restarts the stream, dropping the partial sum
    task automatic test_restart_on_write();
        apply_setting(MODE_SUM, 7'd1, 7'd1, 7'd1, 3'd2, 3'd1, 3'd1, RECIP_ONE);
        send_sample(32'sd5);
        wait_idle();
        write_reg(REG_LAT_FACTOR, CFG_DATA_W'(2));
        cfg_wr_en <= 1'b0;
        send_sample(32'sd7);
        send_sample(32'sd9);
    endtask

    // receiver holds off while 64-cell runs pile up and stall the input
    task automatic test_output_hold();
        apply_setting(MODE_UPSAMPLE, 7'd2, 7'd1, 7'd1, 3'd4, 3'd4, 3'd4, RECIP_ONE);
        hold_requests <= hold_requests + 1;
        repeat (6) send_sample(rand_sample());
    endtask

    // sender pauses mid-grid until the block has drained, then carries on
    task automatic test_drain_pause();
        apply_setting(MODE_AVERAGE, 7'd2, 7'd2, 7'd1, 3'd2, 3'd2, 3'd1, pick_recip());
        repeat (8) send_sample(rand_sample());
        wait_idle();
        repeat (8) send_sample(rand_sample());
    endtask

    // random setting, then a full grid when small or a slice of a large one
    task automatic random_phase();
        mode_t mode;
        logic [CELLS_W-1:0] lc, oc, dc;
        logic [FACTOR_W-1:0] lf, of_, df;
        int unsigned grid, n;
        mode = mode_t'($urandom_range(0, 3));
        lc   = pick_cells();
        oc   = pick_cells();
        dc   = pick_cells();
        lf   = FACTOR_W'($urandom_range(0, 7));
        of_  = FACTOR_W'($urandom_range(0, 7));
        df   = FACTOR_W'($urandom_range(0, 7));
        apply_setting(mode, lc, oc, dc, lf, of_, df, pick_recip());
        grid = eff_cells(lc) * eff_cells(oc) * eff_cells(dc);
        if (mode == MODE_AVERAGE || mode == MODE_SUM)
            grid = grid * eff_factor(lf) * eff_factor(of_) * eff_factor(df);
        if (grid <= 48)
            n = grid + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        else
            n = $urandom_range(8, 48);
        // keep the total item count near its budget
        if (n > RANDOM_ITEMS - random_items)
            n = RANDOM_ITEMS - random_items;
        repeat (n) begin
            send_sample(rand_sample());
            random_items++;
        end
    endtask

    // receiver: randomly chosen stall styles, plus long holds
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_left  = $urandom_range(10, 60);
            end else begin
                rx_left--;
            end
            case (rx_style)
                0, 1:    m_ready <= 1'b1;
                2:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare each accepted cell with the oldest one owed
    always @(posedge aclk) begin : check_cells
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: cell with none owed: expected none, actual index %0d value %0d",
                             $time, m_cell_index, m_cell_value);
            end else begin
                want = expected_cells.pop_front();
                results_checked++;
                if (m_cell_index !== want.index) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: cell_index expected %0d actual %0d",
                                 $time, want.index, m_cell_index);
                end
                if (m_cell_value !== want.value) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $time, want.value, m_cell_value);
                end
                if (m_last_of_run !== want.last_of_run) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last_of_run, m_last_of_run);
                end
                if (m_grid_done !== want.grid_done) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: grid_done expected %0b actual %0b",
                                 $time, want.grid_done, m_grid_done);
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run hit %0d cycles with %0d cells still owed",
                 $time, CYCLE_LIMIT, expected_cells.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_pass_wrap();
        test_upsample_clamped();
        test_sum_saturation();
        test_average_rounding();
        test_restart_on_write();
        test_output_hold();
        test_drain_pause();
        while (random_items < RANDOM_ITEMS) random_phase();

        wait_idle();
        $display("sent %0d items (%0d random) over %0d register settings, %0d cells checked",
                 items_sent, random_items, settings_run, results_checked);
        $display("all four modes, clamped sizes and reciprocals, stream restart, long output hold");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
